@@ rtl/core/cbt_pkg.sv @@
// cbt_pkg: shared types, codes and helpers for the circuit breaker table
// depends on nothing; imported by every module under rtl/core
package cbt_pkg;

  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // breaker state codes
  typedef enum logic [1:0] {
    BRK_CLOSED = 2'd0,
    BRK_OPEN   = 2'd1,
    BRK_HALF   = 2'd2
  } brk_state_e;

  // operation codes carried by mode
  typedef enum logic [2:0] {
    OP_SUCCESS     = 3'd0,
    OP_FAILURE     = 3'd1,
    OP_CHECK       = 3'd2,
    OP_BEGIN       = 3'd3,
    OP_END         = 3'd4,
    OP_QUERY       = 3'd5,
    OP_RESET_ENTRY = 3'd6,
    OP_RESET_ALL   = 3'd7
  } op_e;

  // configuration register indexes (word address)
  typedef enum logic [1:0] {
    REG_FAILURE_LIMIT = 2'd0,
    REG_SUCCESS_LIMIT = 2'd1,
    REG_COOLDOWN_MS   = 2'd2,
    REG_PROBE_LIMIT   = 2'd3
  } reg_idx_e;

  localparam int unsigned PADDR_W = 4;

  localparam logic [7:0]  RST_FAILURE_LIMIT = 8'd5;
  localparam logic [7:0]  RST_SUCCESS_LIMIT = 8'd2;
  localparam logic [31:0] RST_COOLDOWN_MS   = 32'd30000;
  localparam logic [7:0]  RST_PROBE_LIMIT   = 8'd1;

  typedef struct packed {
    logic [7:0]  failure_limit;
    logic [7:0]  success_limit;
    logic [31:0] cooldown_ms;
    logic [7:0]  probe_limit;
  } cfg_t;

  // per-entry breaker record, all zero means closed with no counts
  typedef struct packed {
    brk_state_e       state;
    logic [CNT_W-1:0] fails;
    logic [CNT_W-1:0] succ;
    logic [CNT_W-1:0] probes;
  } entry_t;

  // write-back control from the update logic to the entry store
  typedef struct packed {
    logic wr_en;
    logic clr_one;
    logic clr_all;
  } wr_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 8'd1;
  endfunction

endpackage

@@ rtl/core/cbt_cfg_regs.sv @@
// cbt_cfg_regs: apb-style configuration registers of the breaker table
// depends on cbt_pkg
module cbt_cfg_regs
  import cbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_FAILURE_LIMIT: cfg_d.failure_limit = pwdata[7:0];
        REG_SUCCESS_LIMIT: cfg_d.success_limit = pwdata[7:0];
        REG_COOLDOWN_MS:   cfg_d.cooldown_ms   = pwdata;
        REG_PROBE_LIMIT:   cfg_d.probe_limit   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FAILURE_LIMIT: prdata = {24'd0, cfg_q.failure_limit};
      REG_SUCCESS_LIMIT: prdata = {24'd0, cfg_q.success_limit};
      REG_COOLDOWN_MS:   prdata = cfg_q.cooldown_ms;
      REG_PROBE_LIMIT:   prdata = {24'd0, cfg_q.probe_limit};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failure_limit <= RST_FAILURE_LIMIT;
      cfg_q.success_limit <= RST_SUCCESS_LIMIT;
      cfg_q.cooldown_ms   <= RST_COOLDOWN_MS;
      cfg_q.probe_limit   <= RST_PROBE_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/cbt_entry_store.sv @@
// cbt_entry_store: breaker record memory with per-entry valid flags and
// write-to-read bypass; depends on cbt_pkg
module cbt_entry_store
  import cbt_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 64,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // read port, item entering the update stage
  input  logic                                       rd_en_i,
  input  logic [((ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1)-1:0] rd_idx_i,
  // index of the item now in the update stage
  input  logic [((ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1)-1:0] cur_idx_i,
  output entry_t                                     cur_entry_o,
  output logic [TIME_BITS-1:0]                       cur_time_o,
  // write-back of the update stage
  input  wr_ctl_t                                    wr_ctl_i,
  input  entry_t                                     wr_entry_i,
  input  logic [TIME_BITS-1:0]                       wr_time_i
);

  entry_t               entry_mem [ENTRY_COUNT];
  logic [TIME_BITS-1:0] time_mem  [ENTRY_COUNT];

  entry_t               rd_entry_q;
  logic [TIME_BITS-1:0] rd_time_q;
  logic                 byp_q;
  entry_t               byp_entry_q;
  logic [TIME_BITS-1:0] byp_time_q;
  logic [ENTRY_COUNT-1:0] valid_q;
  logic [ENTRY_COUNT-1:0] valid_d;
  logic                 byp_d;

  assign byp_d = rd_en_i && wr_ctl_i.wr_en && (rd_idx_i == cur_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.wr_en) begin
      entry_mem[cur_idx_i] <= wr_entry_i;
      time_mem[cur_idx_i]  <= wr_time_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= entry_mem[rd_idx_i];
      rd_time_q  <= time_mem[rd_idx_i];
    end
    byp_entry_q <= wr_entry_i;
    byp_time_q  <= wr_time_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_ctl_i.clr_all) begin
      valid_d = '0;
    end else if (wr_ctl_i.clr_one) begin
      valid_d[cur_idx_i] = 1'b0;
    end else if (wr_ctl_i.wr_en) begin
      valid_d[cur_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        byp_q <= byp_d;
      end
    end
  end

  // an entry that is not valid reads as closed with zero counts
  always_comb begin
    if (!valid_q[cur_idx_i]) begin
      cur_entry_o = '0;
      cur_time_o  = '0;
    end else if (byp_q) begin
      cur_entry_o = byp_entry_q;
      cur_time_o  = byp_time_q;
    end else begin
      cur_entry_o = rd_entry_q;
      cur_time_o  = rd_time_q;
    end
  end

endmodule

@@ rtl/core/cbt_update.sv @@
// cbt_update: next-state and result logic for one breaker entry
// depends on cbt_pkg
module cbt_update
  import cbt_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  op_e                  op_i,
  input  logic                 in_range_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  cfg_t                 cfg_i,
  input  entry_t               cur_i,
  input  logic [TIME_BITS-1:0] cur_time_i,
  output entry_t               nxt_o,
  output logic [TIME_BITS-1:0] nxt_time_o,
  output wr_ctl_t              wr_ctl_o,
  output logic                 allowed_o
);

  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [CNT_W-1:0]     fail_inc;
  logic [CNT_W-1:0]     succ_inc;
  logic [CNT_W-1:0]     probe_inc;
  logic [TIME_BITS-1:0] elapsed;
  logic                 cooled;

  assign fail_inc  = sat_inc(cur_i.fails);
  assign succ_inc  = sat_inc(cur_i.succ);
  assign probe_inc = sat_inc(cur_i.probes);
  // wrapping time difference, compared with the full cooldown value
  assign elapsed   = now_i - cur_time_i;
  assign cooled    = CMP_W'(elapsed) >= CMP_W'(cfg_i.cooldown_ms);

  always_comb begin
    nxt_o      = cur_i;
    nxt_time_o = cur_time_i;
    wr_ctl_o   = '0;
    allowed_o  = 1'b0;
    if (!in_range_i) begin
      nxt_o = '0;
    end else begin
      case (op_i)
        OP_SUCCESS: begin
          wr_ctl_o.wr_en = 1'b1;
          if (cur_i.state == BRK_HALF) begin
            if (succ_inc >= cfg_i.success_limit) begin
              nxt_o = '0;
            end else begin
              nxt_o.succ = succ_inc;
            end
          end else if (cur_i.state == BRK_CLOSED) begin
            nxt_o.fails = '0;
          end
        end
        OP_FAILURE: begin
          wr_ctl_o.wr_en = 1'b1;
          nxt_o.fails    = fail_inc;
          if (cur_i.state == BRK_CLOSED) begin
            if (fail_inc >= cfg_i.failure_limit) begin
              nxt_o.state = BRK_OPEN;
              nxt_time_o  = now_i;
            end
          end else if (cur_i.state == BRK_HALF) begin
            nxt_o.state  = BRK_OPEN;
            nxt_o.succ   = '0;
            nxt_o.probes = '0;
            nxt_time_o   = now_i;
          end
        end
        OP_CHECK: begin
          wr_ctl_o.wr_en = 1'b1;
          if (cur_i.state == BRK_CLOSED) begin
            allowed_o = 1'b1;
          end else if (cur_i.state == BRK_OPEN) begin
            if (cooled) begin
              nxt_o.state  = BRK_HALF;
              nxt_o.succ   = '0;
              nxt_o.probes = '0;
              allowed_o    = 1'b1;
            end
          end else begin
            allowed_o = cur_i.probes < cfg_i.probe_limit;
          end
        end
        OP_BEGIN: begin
          wr_ctl_o.wr_en = 1'b1;
          if (cur_i.state == BRK_HALF) begin
            nxt_o.probes = probe_inc;
          end
        end
        OP_END: begin
          wr_ctl_o.wr_en = 1'b1;
          if (cur_i.probes != '0) begin
            nxt_o.probes = cur_i.probes - 8'd1;
          end
        end
        OP_QUERY: ;
        OP_RESET_ENTRY: begin
          wr_ctl_o.clr_one = 1'b1;
          nxt_o            = '0;
        end
        OP_RESET_ALL: begin
          wr_ctl_o.clr_all = 1'b1;
          nxt_o            = '0;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/circuit_breaker_table_top.sv @@
// circuit_breaker_table_top: table of per-path circuit breakers
// depends on cbt_pkg, cbt_cfg_regs, cbt_entry_store, cbt_update
//
//  channel   direction  handshake                      payload
//  -------   ---------  -----------------------------  -------------------------------------
//  request   in         start high, busy low           mode_i, entry_index_i, now_ms_i
//  result    out        done_o strobe, one cycle       allowed_o, breaker_state_o, failures_o
//  config    in/out     psel & penable & pwrite        paddr, pwdata, prdata, pready
//
// an item is taken in every cycle; busy stays low
// each result shows on done_o after the registered memory read and then the
// update logic into the result register
// the rate is set by the single read-modify-write of the record memory; a
// write and a read of the same entry in one cycle are resolved by a bypass
// reset clears the control flags and every entry's valid flag at once, so
// the table needs no clearing pass; results cannot be stalled by the receiver
module circuit_breaker_table_top
  import cbt_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT = 64,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request items
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode_i,
  input  logic [5:0]         entry_index_i,
  input  logic [31:0]        now_ms_i,
  // result items
  output logic               done_o,
  output logic               allowed_o,
  output logic [1:0]         breaker_state_o,
  output logic [7:0]         failures_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IDX_W     = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned IDX_EXT_W = (IDX_W > 6) ? IDX_W : 6;
  localparam int unsigned NOW_EXT_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  cfg_t                 cfg;
  logic                 accept;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [IDX_W-1:0]     idx;
  logic [NOW_EXT_W-1:0] now_ext;

  // update stage registers
  logic                 s1_vld_q;
  op_e                  s1_op_q;
  logic [IDX_W-1:0]     s1_idx_q;
  logic                 s1_in_range_q;
  logic [TIME_BITS-1:0] s1_now_q;

  entry_t               cur_entry;
  logic [TIME_BITS-1:0] cur_time;
  entry_t               nxt_entry;
  logic [TIME_BITS-1:0] nxt_time;
  wr_ctl_t              upd_ctl;
  wr_ctl_t              wr_ctl;
  logic                 upd_allowed;

  // result registers
  logic                 done_q;
  logic                 allowed_q;
  logic [1:0]           state_q;
  logic [7:0]           fails_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign idx_ext = IDX_EXT_W'(entry_index_i);
  assign idx     = idx_ext[IDX_W-1:0];
  assign now_ext = NOW_EXT_W'(now_ms_i);

  cbt_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // request capture, memory read issued in the same cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= op_e'(mode_i);
      s1_idx_q      <= idx;
      s1_in_range_q <= 32'(entry_index_i) < ENTRY_COUNT;
      s1_now_q      <= now_ext[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  cbt_entry_store #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .TIME_BITS   (TIME_BITS)
  ) u_entry_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_idx_i    (idx),
    .cur_idx_i   (s1_idx_q),
    .cur_entry_o (cur_entry),
    .cur_time_o  (cur_time),
    .wr_ctl_i    (wr_ctl),
    .wr_entry_i  (nxt_entry),
    .wr_time_i   (nxt_time)
  );

  cbt_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .op_i       (s1_op_q),
    .in_range_i (s1_in_range_q),
    .now_i      (s1_now_q),
    .cfg_i      (cfg),
    .cur_i      (cur_entry),
    .cur_time_i (cur_time),
    .nxt_o      (nxt_entry),
    .nxt_time_o (nxt_time),
    .wr_ctl_o   (upd_ctl),
    .allowed_o  (upd_allowed)
  );

  // write-back only for a live item in the update stage
  always_comb begin
    wr_ctl = '0;
    if (s1_vld_q) begin
      wr_ctl = upd_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      allowed_q <= upd_allowed;
      state_q   <= nxt_entry.state;
      fails_q   <= nxt_entry.fails;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_vld_q;
    end
  end

  assign done_o          = done_q;
  assign allowed_o       = allowed_q;
  assign breaker_state_o = state_q;
  assign failures_o      = fails_q;

endmodule
